@@ design/ghash_pkg.sv @@
package ghash_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int HALF_W      = 64;
    localparam int COUNT_W     = 5;
    localparam int TOTAL_W     = 61;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0]         GF_REDUCE = 8'he1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_KEY_HI = 1'b0,
        CFG_HASH_KEY_LO = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op                op;
        logic [HALF_W-1:0]  block_hi;
        logic [HALF_W-1:0]  block_lo;
        logic [COUNT_W-1:0] byte_count;
        logic               is_aad;
    } t_blk_req;

    typedef struct packed {
        logic [HALF_W-1:0] hash_hi;
        logic [HALF_W-1:0] hash_lo;
    } t_hash_req;

endpackage

@@ design/ghash_stream_if.sv @@
interface ghash_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/ghash_accumulator_top.sv @@
// GHASH accumulator for GCM. Load the hash subkey H through the write port
// (index 0 for bytes 0 to 7, index 1 for bytes 8 to 15) while no request is
// in flight. Each absorb request XORs one 128-bit block, with bytes past
// byte_count zeroed, into the accumulator and multiplies by H; a byte count of
// zero is dropped and counts above sixteen are taken as sixteen. AAD and
// ciphertext byte totals saturate at 2^61-1. A finish request folds in the
// bit-length block, returns the hash on the output channel and clears the
// accumulator and totals. The block takes one request every cycle unless a
// finish waits on a held-off output, the only case in which input ready
// drops: a fully parallel GF(2^128) multiplier closes the accumulator loop,
// so the input register, the multiplier stage and the output register stream
// without bubbles; a finish's hash is registered in the output register.
module ghash_accumulator_top
    import ghash_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ghash_stream_if.sink          i_blk,
    ghash_stream_if.source        o_hash
);

    // Multiply in the bit-reflected GF(2^128) form. The shifted copies of h
    // depend on the key alone, so the only data path is one XOR tree per bit.
    function automatic logic [BLOCK_W-1:0] gf_mult(
        input logic [BLOCK_W-1:0] x,
        input logic [BLOCK_W-1:0] h
    );
        logic [BLOCK_W-1:0] z;
        logic [BLOCK_W-1:0] v;
        logic               lsb;
        z = '0;
        v = h;
        for (int i = 0; i < BLOCK_W; i++) begin
            if (x[BLOCK_W-1-i]) begin
                z = z ^ v;
            end
            lsb = v[0];
            v   = v >> 1;
            if (lsb) begin
                v[BLOCK_W-1 -: 8] = v[BLOCK_W-1 -: 8] ^ GF_REDUCE;
            end
        end
        return z;
    endfunction

    logic [HALF_W-1:0]  r_key_hi;
    logic [HALF_W-1:0]  r_key_lo;

    logic               r_in_valid;
    t_op                r_in_op;
    logic [BLOCK_W-1:0] r_in_block;
    logic [COUNT_W-1:0] r_in_count;
    logic               r_in_aad;

    logic [BLOCK_W-1:0] r_acc;
    logic [TOTAL_W-1:0] r_aad_total;
    logic [TOTAL_W-1:0] r_text_total;

    logic               r_out_valid;
    t_hash_req          r_out;

    logic               w_take;
    logic               w_keep;
    logic               w_fire;
    logic [COUNT_W-1:0] w_count;
    logic [BLOCK_W-1:0] w_mask;
    logic [BLOCK_W-1:0] w_gf_in;
    logic [BLOCK_W-1:0] w_prod;
    logic [TOTAL_W-1:0] w_total_sel;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_total_next;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HASH_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_HASH_KEY_LO: r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: clamp the byte count and zero the bytes past it.
    assign w_count = (i_blk.payload.byte_count > COUNT_W'(BLOCK_BYTES))
                   ? COUNT_W'(BLOCK_BYTES) : i_blk.payload.byte_count;

    always_comb begin
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            w_mask[BLOCK_W-1-8*j -: 8] = (COUNT_W'(j) < w_count) ? 8'hff : 8'h00;
        end
    end

    assign w_fire = r_in_valid
                 && (r_in_op == OP_ABSORB || !r_out_valid || o_hash.ready);
    assign i_blk.ready = !r_in_valid || w_fire;
    assign w_take = i_blk.valid && i_blk.ready;
    // An absorb with no valid bytes leaves the state alone, so it is dropped here.
    assign w_keep = (i_blk.payload.op == OP_FINISH) || (i_blk.payload.byte_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_blk.ready) begin
            r_in_valid <= w_take && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_op    <= i_blk.payload.op;
            r_in_block <= {i_blk.payload.block_hi, i_blk.payload.block_lo} & w_mask;
            r_in_count <= w_count;
            r_in_aad   <= i_blk.payload.is_aad;
        end
    end

    // Multiply stage.
    assign w_gf_in = (r_in_op == OP_FINISH)
                   ? r_acc ^ {r_aad_total, 3'b000, r_text_total, 3'b000}
                   : r_acc ^ r_in_block;
    assign w_prod = gf_mult(w_gf_in, {r_key_hi, r_key_lo});

    assign w_total_sel = r_in_aad ? r_aad_total : r_text_total;
    assign w_sum = {1'b0, w_total_sel} + (TOTAL_W + 1)'(r_in_count);
    assign w_total_next = (w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_aad_total  <= '0;
            r_text_total <= '0;
        end else if (w_fire) begin
            if (r_in_op == OP_FINISH) begin
                r_acc        <= '0;
                r_aad_total  <= '0;
                r_text_total <= '0;
            end else begin
                r_acc <= w_prod;
                if (r_in_aad) begin
                    r_aad_total <= w_total_next;
                end else begin
                    r_text_total <= w_total_next;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_op == OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (o_hash.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_op == OP_FINISH) begin
            r_out.hash_hi <= w_prod[BLOCK_W-1:HALF_W];
            r_out.hash_lo <= w_prod[HALF_W-1:0];
        end
    end

    assign o_hash.valid   = r_out_valid;
    assign o_hash.payload = r_out;

`ifndef SYNTH
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == OP_FINISH)
        |=> (r_acc == '0 && r_aad_total == '0 && r_text_total == '0))
        else $error("finish did not clear the accumulator state");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_blk.ready |-> (r_in_valid && r_in_op == OP_FINISH && r_out_valid))
        else $error("input held off without a waiting finish");

    a_absorb_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == OP_ABSORB && !r_out_valid) |=> !r_out_valid)
        else $error("absorb request produced a result");
`endif

endmodule

@@ test/ghash_result_checker.sv @@
`timescale 1ns / 100ps

module ghash_result_checker
    import ghash_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_blk_valid,
    input  logic                  i_blk_ready,
    input  t_blk_req              i_blk,
    input  logic                  i_hash_valid,
    input  logic                  i_hash_ready,
    input  t_hash_req             i_hash,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    logic [BLOCK_W-1:0] hash_key;
    logic [BLOCK_W-1:0] ghash_acc;
    logic [TOTAL_W-1:0] aad_bytes;
    logic [TOTAL_W-1:0] text_bytes;
    t_hash_req          expected_hashes[$];

    // Bit-serial GF(2^128) product in the reflected bit order: bit 127 of a
    // vector is the coefficient of x^0.
    function automatic logic [BLOCK_W-1:0] gf128_mul(input logic [BLOCK_W-1:0] x,
                                                      input logic [BLOCK_W-1:0] y);
        logic [BLOCK_W-1:0] z;
        logic [BLOCK_W-1:0] v;
        logic               carry;
        z = '0;
        v = y;
        for (int i = BLOCK_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                z ^= v;
            end
            carry = v[0];
            v = v >> 1;
            if (carry) begin
                v[BLOCK_W-1 -: 8] ^= GF_REDUCE;
            end
        end
        return z;
    endfunction

    function automatic logic [TOTAL_W-1:0] add_saturating(input logic [TOTAL_W-1:0] total,
                                                           input int n);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, total} + (TOTAL_W + 1)'(n);
        if (sum >= {1'b0, TOTAL_MAX}) begin
            return TOTAL_MAX;
        end
        return sum[TOTAL_W-1:0];
    endfunction

    task automatic apply_request(input t_blk_req r);
        logic [BLOCK_W-1:0] data;
        int                 n;
        t_hash_req          h;
        if (r.op == OP_ABSORB) begin
            n = r.byte_count;
            if (n != 0) begin
                if (n > BLOCK_BYTES) begin
                    n = BLOCK_BYTES;
                end
                // Keep the leading n bytes; a full block shifts the mask out entirely.
                data = {r.block_hi, r.block_lo} & ~({BLOCK_W{1'b1}} >> (8 * n));
                ghash_acc = gf128_mul(ghash_acc ^ data, hash_key);
                if (r.is_aad) begin
                    aad_bytes = add_saturating(aad_bytes, n);
                end else begin
                    text_bytes = add_saturating(text_bytes, n);
                end
            end
        end else begin
            ghash_acc = gf128_mul(ghash_acc ^ {aad_bytes, 3'b000, text_bytes, 3'b000},
                                  hash_key);
            h.hash_hi = ghash_acc[BLOCK_W-1:HALF_W];
            h.hash_lo = ghash_acc[HALF_W-1:0];
            expected_hashes.push_back(h);
            ghash_acc  = '0;
            aad_bytes  = '0;
            text_bytes = '0;
        end
    endtask

    task automatic check_hash(input t_hash_req got);
        t_hash_req want;
        if (expected_hashes.size() == 0) begin
            $display("%0t: hash with no finish pending: expected none, got %h_%h",
                     $time, got.hash_hi, got.hash_lo);
            o_fail_count++;
        end else begin
            want = expected_hashes.pop_front();
            o_checked++;
            if (got.hash_hi !== want.hash_hi) begin
                $display("%0t: hash_hi mismatch: expected %h, got %h",
                         $time, want.hash_hi, got.hash_hi);
                o_fail_count++;
            end
            if (got.hash_lo !== want.hash_lo) begin
                $display("%0t: hash_lo mismatch: expected %h, got %h",
                         $time, want.hash_lo, got.hash_lo);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hash_key   = '0;
            ghash_acc  = '0;
            aad_bytes  = '0;
            text_bytes = '0;
            expected_hashes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HASH_KEY_HI: hash_key[BLOCK_W-1:HALF_W] = i_cfg_data;
                    CFG_HASH_KEY_LO: hash_key[HALF_W-1:0] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_hash_valid && i_hash_ready) begin
                check_hash(i_hash);
            end
            if (i_blk_valid && i_blk_ready) begin
                apply_request(i_blk);
            end
        end
        o_pending = expected_hashes.size();
    end

endmodule

@@ test/tb_ghash_accumulator_top.sv @@
`timescale 1ns / 100ps

module tb_ghash_accumulator_top;
    import ghash_pkg::*;

    localparam int RANDOM_REQUESTS = 850;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_LIMIT     = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ghash_stream_if #(.T(t_blk_req))  blk_ch ();
    ghash_stream_if #(.T(t_hash_req)) hash_ch ();

    int fail_count;
    int pending;
    int checked;
    int sent;
    int finishes;
    int keys_loaded;
    int burst_left;

    ghash_accumulator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_blk      (blk_ch),
        .o_hash     (hash_ch)
    );

    ghash_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_blk_valid  (blk_ch.valid),
        .i_blk_ready  (blk_ch.ready),
        .i_blk        (blk_ch.payload),
        .i_hash_valid (hash_ch.valid),
        .i_hash_ready (hash_ch.ready),
        .i_hash       (hash_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Run stopped at the time limit with %0d hashes outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    // The hash receiver switches between free flow, random stalls, sparse
    // acceptance and a fixed duty cycle, each held for a random stretch.
    initial begin
        int mode;
        int left;
        int cyc;
        hash_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        cyc  = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 160);
            end
            left--;
            cyc++;
            case (mode)
                0: hash_ch.ready <= 1'b1;
                1: hash_ch.ready <= 1'($urandom_range(0, 1));
                2: hash_ch.ready <= ($urandom_range(0, 3) == 0);
                default: hash_ch.ready <= ((cyc % 11) < 4);
            endcase
        end
    end

    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_blk_req make_request(input t_op op, input logic [COUNT_W-1:0] cnt,
                                              input logic aad, input logic [HALF_W-1:0] hi,
                                              input logic [HALF_W-1:0] lo);
        t_blk_req r;
        r.op         = op;
        r.byte_count = cnt;
        r.is_aad     = aad;
        r.block_hi   = hi;
        r.block_lo   = lo;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_blk_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 4);
            if (gap > 0) begin
                blk_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 12);
        end
        blk_ch.valid   <= 1'b1;
        blk_ch.payload <= r;
        do @(posedge i_clk); while (!blk_ch.ready);
        @(negedge i_clk);
        burst_left--;
        sent++;
        if (r.op == OP_FINISH) begin
            finishes++;
        end
    endtask

    task automatic send_random(input t_op op, input logic [COUNT_W-1:0] cnt, input logic aad);
        send_request(make_request(op, cnt, aad, rand_half(), rand_half()));
    endtask

    // Lets the output drain and the pipeline empty, so that a key write
    // cannot land on an absorb still in flight.
    task automatic wait_idle();
        int guard;
        guard = 0;
        blk_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] which, input logic [HALF_W-1:0] hi,
                            input logic [HALF_W-1:0] lo);
        if (which[0]) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_HASH_KEY_HI;
            cfg_data <= hi;
            @(negedge i_clk);
        end
        if (which[1]) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_HASH_KEY_LO;
            cfg_data <= lo;
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        keys_loaded++;
    endtask

    // Most messages are AAD then ciphertext with a short last block; the rest
    // mix the kinds, drop zero counts, overrun sixteen and finish early.
    task automatic send_message();
        int n_aad;
        int n_text;
        int n;
        if ($urandom_range(0, 9) < 7) begin
            n_aad  = $urandom_range(0, 3);
            n_text = $urandom_range(0, 5);
            for (int i = 0; i < n_aad; i++) begin
                send_random(OP_ABSORB,
                            COUNT_W'((i == n_aad - 1)
                                     ? $urandom_range(1, BLOCK_BYTES) : BLOCK_BYTES),
                            1'b1);
            end
            for (int i = 0; i < n_text; i++) begin
                send_random(OP_ABSORB,
                            COUNT_W'((i == n_text - 1)
                                     ? $urandom_range(1, BLOCK_BYTES) : BLOCK_BYTES),
                            1'b0);
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                send_random(($urandom_range(0, 5) == 0) ? OP_FINISH : OP_ABSORB,
                            COUNT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end
        end
        send_random(OP_FINISH, COUNT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int random_start;
        int phase;
        int leftover;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_HASH_KEY_HI;
        cfg_data       = '0;
        blk_ch.valid   = 1'b0;
        blk_ch.payload = '0;
        sent           = 0;
        finishes       = 0;
        keys_loaded    = 0;
        burst_left     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The key is still zero from reset, so this hash must be zero.
        send_random(OP_FINISH, '1, 1'b1);
        wait_idle();
        load_key(2'b11, {$urandom, $urandom}, {$urandom, $urandom});

        // An empty message, and one whose only block has no valid bytes.
        send_request(make_request(OP_FINISH, '1, 1'b1, '1, '1));
        send_request(make_request(OP_ABSORB, '0, 1'b1, '1, '1));
        send_request(make_request(OP_FINISH, '0, 1'b0, '0, '0));

        // Byte counts around the half and full block, past sixteen, and kinds out of order.
        send_request(make_request(OP_ABSORB, 16, 1'b1, '1, '1));
        send_request(make_request(OP_ABSORB, 1, 1'b1, '1, '1));
        send_request(make_request(OP_ABSORB, 7, 1'b0, '1, '1));
        send_request(make_request(OP_ABSORB, 8, 1'b0, '1, '1));
        send_request(make_request(OP_ABSORB, 9, 1'b0, '1, '1));
        send_request(make_request(OP_ABSORB, 15, 1'b0, '1, '1));
        send_request(make_request(OP_ABSORB, 17, 1'b0, '1, '1));
        send_random(OP_ABSORB, '1, 1'b0);
        send_random(OP_ABSORB, 5, 1'b1);
        send_random(OP_ABSORB, '0, 1'b1);
        send_random(OP_FINISH, COUNT_W'($urandom_range(0, 31)), 1'b0);

        // A zero block still changes the hash through the length block.
        send_request(make_request(OP_ABSORB, 16, 1'b0, '0, '0));
        send_request(make_request(OP_FINISH, 16, 1'b0, '0, '0));
        send_random(OP_FINISH, 3, 1'b1);
        send_random(OP_FINISH, 12, 1'b0);
        wait_idle();

        // With H as the multiplicative identity the hash is the plain XOR sum.
        load_key(2'b11, {1'b1, 63'b0}, '0);
        send_random(OP_ABSORB, 16, 1'b1);
        send_random(OP_FINISH, 0, 1'b0);
        wait_idle();

        random_start = sent;
        phase = 0;
        while (sent - random_start < RANDOM_REQUESTS) begin
            case (phase % 6)
                0: load_key(2'b11, {$urandom, $urandom}, {$urandom, $urandom});
                1: load_key(2'b11, '1, '1);
                2: load_key(2'b11, '0, '0);
                3: load_key(2'b11, {1'b1, 63'b0}, '0);
                4: load_key(2'b01, {$urandom, $urandom}, '0);
                default: load_key(2'b10, '0, {$urandom, $urandom});
            endcase
            repeat ($urandom_range(3, 10)) send_message();
            wait_idle();
            phase++;
        end

        leftover = pending;
        if (leftover != 0) begin
            $display("%0t: %0d expected hashes never arrived", $time, leftover);
        end
        $display("Sent %0d requests, %0d of them finishes, across %0d hash key loads.",
                 sent, finishes, keys_loaded);
        $display("Compared %0d hashes against the predicted values.", checked);
        if (fail_count == 0 && leftover == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ghash_pkg.sv
design/ghash_stream_if.sv
design/ghash_accumulator_top.sv
test/ghash_result_checker.sv
test/tb_ghash_accumulator_top.sv
